[rtl/core/iee_pkg.sv]
`timescale 1ns / 1ps
package iee_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned DataW = 32;

  localparam logic [2:0] OpParen = 3'd0;
  localparam logic [2:0] OpAdd   = 3'd1;
  localparam logic [2:0] OpSub   = 3'd2;
  localparam logic [2:0] OpMul   = 3'd3;
  localparam logic [2:0] OpDiv   = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StParens   = 3'd1;
  localparam logic [2:0] StDivZero  = 3'd2;
  localparam logic [2:0] StBadChar  = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  localparam logic [7:0] ChEnd    = 8'h40;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  function automatic logic [2:0] op_code(input logic [7:0] c);
    case (c)
      ChPlus:  op_code = OpAdd;
      ChMinus: op_code = OpSub;
      ChStar:  op_code = OpMul;
      ChSlash: op_code = OpDiv;
      default: op_code = OpParen;
    endcase
  endfunction
endpackage

[rtl/core/infix_expression_evaluator_unit.sv]
`timescale 1ns / 1ps
// Infix expression evaluator.
// Input channel (char_valid_i/char_ready_o, char_code_i): one ASCII character
// per item; digits, + - * / ( ) and '@' which ends the expression.
// Output channel (res_valid_o/res_ready_i, value_o, status_o): one item per
// '@' carrying the 32-bit result and status (0 ok, 1 parens, 2 div by zero,
// 3 bad char, 4 overflow); value is 0 on error.
// An operator or ')' also runs one reduction per popped operator; a / reduction
// uses the shared divider, one quotient bit per cycle.
// A '@' shows its result after the reductions, and input is ready again in
// the same cycle that the result appears.
// Reductions read the operand stack RAM one entry per cycle.
// The result sits in an output register; input is accepted again while it
// waits, but a second '@' stalls until the first result is taken.
// Reset clears all control state and empties the stacks; stack RAM contents
// are not cleared (entries are written before read).
module infix_expression_evaluator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_valid_i,
  output logic        char_ready_o,
  input  logic [7:0]  char_code_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic signed [31:0] value_o,
  output logic [2:0]  status_o
);
  import iee_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SDecode = 4'd1, SLoop = 4'd2,
                         SRdB = 4'd3, SRdA = 4'd4, SExec = 4'd5,
                         SDiv = 4'd6, SWrite = 4'd7, SPush = 4'd8,
                         SClose = 4'd9, SEndRd = 4'd10, SEmit = 4'd11;
  // loop kinds
  localparam logic [1:0] KOp = 2'd0, KClose = 2'd1, KEnd = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] ch_q, ch_d;
  logic [PtrW-1:0] top_q, top_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [PtrW:0] depth_q, depth_d;
  logic [2:0] err_q, err_d;
  logic expect_q, expect_d, digits_q, digits_d;
  logic [2:0] opnew_q, opnew_d;

  // stacks
  logic [DataW-1:0] opnd_mem [StackDepth];
  logic [2:0] oper_mem [StackDepth];
  logic opnd_we, oper_we;
  logic [PtrW-1:0] opnd_waddr, opnd_raddr, oper_waddr, oper_raddr;
  logic [DataW-1:0] opnd_wdata, opnd_rdata_q;
  logic [2:0] oper_wdata;
  logic [2:0] topop_q; // operator read at oper_raddr last cycle

  always_ff @(posedge clk_i) begin
    if (opnd_we) opnd_mem[opnd_waddr] <= opnd_wdata;
    opnd_rdata_q <= opnd_mem[opnd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (oper_we) oper_mem[oper_waddr] <= oper_wdata;
    topop_q <= oper_mem[oper_raddr];
  end

  // operands for reduction
  logic [DataW-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic [2:0] rop_q, rop_d;

  // shared divider: magnitude restoring, one bit per cycle
  logic [DataW-1:0] dq_q, dq_d, drem_q, drem_d, dden_q, dden_d;
  logic [5:0] dcnt_q, dcnt_d;
  logic dneg_q, dneg_d;
  logic [DataW:0] dtrial;
  logic [DataW-1:0] dshift;

  // output register
  logic res_valid_q, res_valid_d;
  logic [DataW-1:0] val_q, val_d;
  logic [2:0] stat_q, stat_d;

  assign res_valid_o = res_valid_q;
  assign value_o = val_q;
  assign status_o = stat_q;
  assign char_ready_o = (state_q == SIdle);

  logic [DataW-1:0] mul10;
  logic [DataW-1:0] prod;
  logic is_digit;
  logic [2:0] cop;

  always_comb begin
    state_d = state_q; kind_d = kind_q; ch_d = ch_q; top_d = top_q;
    acc_d = acc_q; depth_d = depth_q; err_d = err_q; expect_d = expect_q;
    digits_d = digits_q; opnew_d = opnew_q; a_d = a_q; b_d = b_q; r_d = r_q;
    rop_d = rop_q; dq_d = dq_q; drem_d = drem_q; dden_d = dden_q;
    dcnt_d = dcnt_q; dneg_d = dneg_q; res_valid_d = res_valid_q;
    val_d = val_q; stat_d = stat_q;
    opnd_we = 1'b0; opnd_waddr = top_q; opnd_wdata = acc_q;
    opnd_raddr = top_q; oper_we = 1'b0; oper_waddr = top_q + 1'b1;
    oper_wdata = opnew_q; oper_raddr = top_q;
    is_digit = (ch_q >= ChZero) && (ch_q <= ChNine);
    cop = op_code(ch_q);
    mul10 = (acc_q << 3) + (acc_q << 1) + {24'd0, ch_q - ChZero};
    prod = a_q * b_q;
    dshift = {drem_q[DataW-2:0], dq_q[DataW-1]};
    dtrial = {1'b0, dshift} - {1'b0, dden_q};

    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;

    case (state_q)
      SIdle: begin
        if (char_valid_i) begin
          ch_d = char_code_i;
          state_d = SDecode;
        end
      end
      SDecode: begin
        state_d = SIdle;
        if (ch_q == ChEnd) begin
          kind_d = KEnd;
          if (err_q == StOk) begin
            if (expect_q) begin
              opnd_we = 1'b1;
              acc_d = '0; digits_d = 1'b0;
            end
            if (depth_q != '0) err_d = StParens;
          end
          state_d = SLoop;
        end else if (err_q != StOk) begin
          state_d = SIdle;
        end else if (expect_q && ch_q == ChLParen && !digits_q) begin
          opnew_d = OpParen; state_d = SPush;
        end else if (expect_q && is_digit) begin
          acc_d = mul10; digits_d = 1'b1;
        end else if (ch_q == ChRParen) begin
          if (expect_q) begin
            opnd_we = 1'b1; acc_d = '0; digits_d = 1'b0;
          end
          if (depth_q == '0) err_d = StParens;
          else begin kind_d = KClose; state_d = SLoop; end
        end else if (cop != OpParen) begin
          if (expect_q) begin
            opnd_we = 1'b1; acc_d = '0; digits_d = 1'b0;
          end
          opnew_d = cop; kind_d = KOp; state_d = SLoop;
        end else begin
          err_d = StBadChar;
        end
      end
      // topop_q is valid from here on; the operand read at top_q is valid in the state after this one
      SLoop: begin
        rop_d = topop_q;
        case (kind_q)
          KEnd: begin
            if (err_q != StOk) state_d = SEmit;
            else if (top_q != '0) state_d = SRdB;
            else state_d = SEndRd;
          end
          KClose: begin
            if (err_q != StOk || top_q == '0) state_d = SIdle;
            else if (topop_q != OpParen) state_d = SRdB;
            else state_d = SClose;
          end
          default: begin
            if (err_q != StOk) state_d = SIdle;
            else if (top_q != '0 && (((opnew_q == OpAdd || opnew_q == OpSub)
                     && topop_q != OpParen) || topop_q == OpMul || topop_q == OpDiv))
              state_d = SRdB;
            else state_d = SPush;
          end
        endcase
      end
      SRdB: begin
        b_d = opnd_rdata_q;
        opnd_raddr = top_q - 1'b1;
        state_d = SRdA;
      end
      SRdA: begin
        a_d = opnd_rdata_q;
        state_d = SExec;
      end
      SExec: begin
        state_d = SWrite;
        case (rop_q)
          OpAdd: r_d = a_q + b_q;
          OpSub: r_d = a_q - b_q;
          OpMul: r_d = prod;
          OpDiv: begin
            if (b_q == '0) begin
              if (err_q == StOk) err_d = StDivZero;
              r_d = '0;
            end else begin
              dneg_d = a_q[DataW-1] ^ b_q[DataW-1];
              dq_d = a_q[DataW-1] ? -a_q : a_q;
              dden_d = b_q[DataW-1] ? -b_q : b_q;
              drem_d = '0; dcnt_d = 6'd32; state_d = SDiv;
            end
          end
          default: r_d = b_q;
        endcase
      end
      SDiv: begin
        if (dcnt_q == '0) begin
          r_d = dneg_q ? -dq_q : dq_q; state_d = SWrite;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
          if (!dtrial[DataW]) begin
            drem_d = dtrial[DataW-1:0]; dq_d = {dq_q[DataW-2:0], 1'b1};
          end else begin
            drem_d = dshift; dq_d = {dq_q[DataW-2:0], 1'b0};
          end
        end
      end
      SWrite: begin
        opnd_we = 1'b1; opnd_waddr = top_q - 1'b1; opnd_wdata = r_q;
        top_d = top_q - 1'b1; oper_raddr = top_q - 1'b1;
        state_d = SLoop;
      end
      SPush: begin
        if (top_q == PtrW'(StackDepth - 1)) begin
          err_d = StOverflow;
        end else begin
          top_d = top_q + 1'b1;
          oper_we = 1'b1;
          if (opnew_q == OpParen) depth_d = depth_q + 1'b1;
          else expect_d = 1'b1;
        end
        state_d = SIdle;
      end
      // inner value drops into the slot below its '('
      SClose: begin
        opnd_we = 1'b1; opnd_waddr = top_q - 1'b1; opnd_wdata = opnd_rdata_q;
        top_d = top_q - 1'b1;
        depth_d = depth_q - 1'b1; expect_d = 1'b0;
        state_d = SIdle;
      end
      SEndRd: begin
        r_d = opnd_rdata_q;
        state_d = SEmit;
      end
      SEmit: begin
        if (!res_valid_q || res_ready_i) begin
          val_d = (err_q == StOk) ? r_q : '0;
          stat_d = err_q;
          res_valid_d = 1'b1;
          top_d = '0; acc_d = '0; depth_d = '0; err_d = StOk;
          expect_d = 1'b1; digits_d = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; kind_q <= KOp; top_q <= '0; acc_q <= '0;
      depth_q <= '0; err_q <= StOk; expect_q <= 1'b1; digits_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; kind_q <= kind_d; top_q <= top_d; acc_q <= acc_d;
      depth_q <= depth_d; err_q <= err_d; expect_q <= expect_d;
      digits_q <= digits_d; res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; opnew_q <= opnew_d; a_q <= a_d; b_q <= b_d;
    r_q <= r_d;
    rop_q <= rop_d; dq_q <= dq_d; drem_q <= drem_d; dden_q <= dden_d;
    dcnt_q <= dcnt_d; dneg_q <= dneg_d; val_q <= val_d; stat_q <= stat_d;
  end
endmodule
